>>> design/bba_pkg.sv
// Package for the bitmap block allocator: shared types, codes and constants.
// Used by bba_ctrl, bba_dp and the top level bitmap_block_allocator.
// No dependencies.
package bba_pkg;

    // Free map is stored as words of this many bits.
    localparam int MAP_W  = 32;
    localparam int MAP_BW = 5;

    // Register indexes of the configuration port.
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_COUNT = 2'd2;

    // Register reset values.
    localparam logic [31:0] BASE_RST  = 32'd0;
    localparam logic [15:0] SIZE_RST  = 16'd16;
    localparam logic [6:0]  COUNT_RST = 7'd64;

    // Request codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // Divider: one quotient bit per step, 32 steps.
    localparam int          DIV_CW   = 5;
    localparam logic [4:0]  DIV_LAST = 5'd31;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALC_RD,
        S_ALC_CHK,
        S_ALC_MUL,
        S_ALC_ADD,
        S_FRE_PRE,
        S_FRE_DIV,
        S_FRE_IDX,
        S_FRE_CHK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic scan_init;
        logic rd_word;
        logic word_inc;
        logic alc_wr;
        logic mul;
        logic div_load;
        logic div_step;
        logic rd_quo;
        logic fre_wr;
        logic finish;
        logic fail;
        logic addr_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic word_hit;
        logic scan_end;
        logic pre_ok;
        logic div_last;
        logic idx_ok;
        logic blk_used;
    } t_sts;

endpackage

>>> design/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
// Depends on bba_pkg for the state type and the command and status structs.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_opcode,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts the map clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = (i_opcode == OP_FREE) ? S_FRE_PRE : S_ALC_RD;
                end
            end
            S_ALC_RD: begin
                n_state = S_ALC_CHK;
            end
            S_ALC_CHK: begin
                if (i_sts.word_hit) begin
                    n_state = S_ALC_MUL;
                end else if (i_sts.scan_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ALC_RD;
                end
            end
            S_ALC_MUL: begin
                n_state = S_ALC_ADD;
            end
            S_ALC_ADD: begin
                n_state = S_IDLE;
            end
            S_FRE_PRE: begin
                n_state = i_sts.pre_ok ? S_FRE_DIV : S_IDLE;
            end
            S_FRE_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_FRE_IDX;
                end
            end
            S_FRE_IDX: begin
                n_state = i_sts.idx_ok ? S_FRE_CHK : S_IDLE;
            end
            S_FRE_CHK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        busy  = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.scan_init = 1'b1;
                end
            end
            S_ALC_RD: begin
                o_cmd.rd_word = 1'b1;
            end
            S_ALC_CHK: begin
                if (i_sts.word_hit) begin
                    o_cmd.alc_wr = 1'b1;
                end else if (i_sts.scan_end) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.fail   = 1'b1;
                end else begin
                    o_cmd.word_inc = 1'b1;
                end
            end
            S_ALC_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_ALC_ADD: begin
                o_cmd.finish   = 1'b1;
                o_cmd.addr_out = 1'b1;
            end
            S_FRE_PRE: begin
                if (i_sts.pre_ok) begin
                    o_cmd.div_load = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    o_cmd.fail   = 1'b1;
                end
            end
            S_FRE_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_FRE_IDX: begin
                if (i_sts.idx_ok) begin
                    o_cmd.rd_quo = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    o_cmd.fail   = 1'b1;
                end
            end
            S_FRE_CHK: begin
                o_cmd.rd_quo = 1'b0;
                o_cmd.finish = 1'b1;
                if (i_sts.blk_used) begin
                    o_cmd.fre_wr = 1'b1;
                end else begin
                    o_cmd.fail = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> design/bba_dp.sv
// Datapath of the bitmap block allocator: registers, free map memory,
// word scanner, restoring divider, multiplier and result registers. Uses bba_pkg.
module bba_dp
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    input  logic [31:0]       i_free_address,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_strobe,
    output logic              o_status,
    output logic [31:0]       o_block_address
);

    localparam int NW   = (MAX_BLOCKS + MAP_W - 1) / MAP_W;
    localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int IW   = AW + MAP_BW;
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int XW   = (AW + MAP_BW + 1 > CNTW) ? AW + MAP_BW + 1 : CNTW;
    localparam int PW   = IW + 16;
    localparam logic [31:0]   MAX32   = 32'(MAX_BLOCKS);
    localparam logic [AW-1:0] LAST_WD = AW'(NW - 1);

    // Configuration registers.
    logic [31:0] r_base;
    logic [15:0] r_size;
    logic [6:0]  r_cnt;

    // Request and working registers.
    logic [31:0]       r_addr;
    logic [AW-1:0]     r_word;
    logic [31:0]       r_quo;
    logic [15:0]       r_rem;
    logic [DIV_CW-1:0] r_div_cnt;
    logic [IW-1:0]     r_hit_idx;
    logic [PW-1:0]     r_prod;
    logic [MAP_W-1:0]  r_rd_data;

    // Result registers.
    logic        r_strobe;
    logic        r_status;
    logic [31:0] r_out_addr;

    // Free map memory.
    logic [MAP_W-1:0] mem [NW];

    logic [31:0]       eff32;
    logic [XW-1:0]     eff_x;
    logic [XW-1:0]     wb;
    logic [XW-1:0]     nb;
    logic [XW-1:0]     lim;
    logic [MAP_W-1:0]  mask;
    logic [MAP_W-1:0]  cand;
    logic [MAP_BW-1:0] hb;
    logic              hit;
    logic [16:0]       rem_sh;
    logic [16:0]       size17;
    logic              ge;
    logic [AW-1:0]     q_word;
    logic [MAP_BW-1:0] q_bit;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [MAP_W-1:0]  wr_data;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RST;
            r_size <= SIZE_RST;
            r_cnt  <= COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE:  r_base <= i_cfg_wdata;
                CFG_SIZE:  r_size <= i_cfg_wdata[15:0];
                CFG_COUNT: r_cnt  <= i_cfg_wdata[6:0];
                default:   r_base <= r_base;
            endcase
        end
    end

    // Effective block count is the register clamped to the map size.
    assign eff32 = ({25'd0, r_cnt} > MAX32) ? MAX32 : {25'd0, r_cnt};
    assign eff_x = eff32[XW-1:0];

    // Mask of the bits of the current word that lie below the effective count.
    always_comb begin
        wb   = XW'({r_word, {MAP_BW{1'b0}}});
        nb   = wb + XW'(MAP_W);
        lim  = (eff_x > wb) ? (eff_x - wb) : '0;
        if (lim >= XW'(MAP_W)) begin
            mask = '1;
        end else begin
            mask = (MAP_W'(1) << lim[MAP_BW-1:0]) - MAP_W'(1);
        end
    end

    // Lowest free bit of the masked word.
    always_comb begin
        cand = r_rd_data & mask;
        hit  = |cand;
        hb   = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hb = MAP_BW'(i);
            end
        end
    end

    // One restoring division step.
    always_comb begin
        rem_sh = {r_rem, r_quo[31]};
        size17 = {1'b0, r_size};
        ge     = (rem_sh >= size17);
    end

    assign q_word = r_quo[AW+MAP_BW-1:MAP_BW];
    assign q_bit  = r_quo[MAP_BW-1:0];

    // Memory address and write data selection.
    always_comb begin
        rd_addr = i_cmd.rd_quo ? q_word : r_word;
        wr_en   = i_cmd.clr_wr | i_cmd.alc_wr | i_cmd.fre_wr;
        wr_addr = i_cmd.fre_wr ? q_word : r_word;
        if (i_cmd.alc_wr) begin
            wr_data = r_rd_data & ~(MAP_W'(1) << hb);
        end else if (i_cmd.fre_wr) begin
            wr_data = r_rd_data | (MAP_W'(1) << q_bit);
        end else begin
            wr_data = '1;
        end
    end

    // Free map memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_word | i_cmd.rd_quo) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Word pointer, used by the clearing pass and by the allocation scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_cmd.scan_init) begin
            r_word <= '0;
        end else if (i_cmd.clr_wr | i_cmd.word_inc) begin
            r_word <= r_word + AW'(1);
        end
    end

    // Divider iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CW'(1);
        end
    end

    // Request capture, divider, hit index and product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_free_address;
        end
        if (i_cmd.div_load) begin
            r_quo <= r_addr - r_base;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[30:0], ge};
            r_rem <= ge ? 16'(rem_sh - size17) : rem_sh[15:0];
        end
        if (i_cmd.alc_wr) begin
            r_hit_idx <= {r_word, hb};
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_hit_idx) * PW'(r_size);
        end
    end

    // Result strobe, high for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status   <= i_cmd.fail ? ST_FAIL : ST_OK;
            r_out_addr <= i_cmd.addr_out ? (r_base + {{(32-PW){1'b0}}, r_prod}) : 32'd0;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.clr_last = (r_word == LAST_WD);
        o_sts.word_hit = hit;
        o_sts.scan_end = (nb >= eff_x) || (r_word == LAST_WD);
        o_sts.pre_ok   = (r_size != 16'd0) && (r_addr >= r_base);
        o_sts.div_last = (r_div_cnt == DIV_LAST);
        o_sts.idx_ok   = (r_quo < eff32);
        o_sts.blk_used = ~r_rd_data[q_bit];
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_block_address = r_out_addr;

endmodule

>>> design/bitmap_block_allocator.sv
// Top level of the bitmap block allocator.
// Joins bba_ctrl and bba_dp; depends on bba_pkg.
//
// Channel    | Handshake                  | Word
// -----------+----------------------------+--------------------------------------
// request    | start, busy                | i_opcode, i_free_address
// result     | o_strobe (one cycle)       | o_status, o_block_address
// config     | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
// A request word is taken at a clock edge with start high and busy low.
// Allocate reads and checks each 32-bit map word in turn, then multiplies the hit index by
// the block size and adds the base; a failed allocate answers from its last word check.
// Free runs the one-bit-per-cycle divider, then checks the index and the map bit; a zero
// block size or an address below the base fails before the divider, an index past the
// block count after it. After reset the map is cleared word by word with busy high; no stalls.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [31:0]       i_free_address,
    output logic              o_strobe,
    output logic              o_status,
    output logic [31:0]       o_block_address
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    bba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Map, divider and result registers.
    bba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_free_address  (i_free_address),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_block_address (o_block_address)
    );

endmodule
